/* rtl/fqp_pkg.sv */
package fqp_pkg;

  // input word: one text byte or an end-of-stream marker
  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
  } fqp_in_t;

  // output word: one character or a record end status
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_out;
    logic [1:0]  status;
    logic [15:0] base_total;
  } fqp_out_t;

  // result of one step, handed from the parse core to the output stage
  typedef struct packed {
    logic     valid;
    fqp_out_t word;
  } fqp_res_t;

  typedef enum logic [5:0] {
    PH_AWAIT   = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_BADSKIP = 6'b000100,
    PH_SEQ     = 6'b001000,
    PH_PLUS    = 6'b010000,
    PH_QUAL    = 6'b100000
  } fqp_phase_e;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BASE = 2'd1;
  localparam logic [1:0] KIND_QUAL = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADHDR   = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [15:0] BASE_TOTAL_MAX = 16'hFFFF;

endpackage

/* rtl/fqp_core.sv */
module fqp_core import fqp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  fqp_in_t  word_i,
  output fqp_res_t res_o
);

  localparam int WideBits = COUNT_BITS + 16;

  fqp_phase_e            phase_q, phase_d;
  logic                  line_start_q, line_start_d;
  logic [COUNT_BITS-1:0] base_cnt_q, base_cnt_d;
  logic [COUNT_BITS-1:0] qual_cnt_q, qual_cnt_d;

  logic [COUNT_BITS-1:0] base_inc, qual_inc;
  logic [WideBits-1:0]   base_wide;
  logic [15:0]           base_total;
  logic                  cnt_equal, qual_done;
  logic [7:0]            b;

  assign b         = word_i.byte_in;
  assign base_inc  = (&base_cnt_q) ? base_cnt_q : base_cnt_q + COUNT_BITS'(1);
  assign qual_inc  = (&qual_cnt_q) ? qual_cnt_q : qual_cnt_q + COUNT_BITS'(1);
  assign base_wide = {16'd0, base_cnt_q};
  assign base_total = (base_wide > WideBits'(BASE_TOTAL_MAX)) ? BASE_TOTAL_MAX
                                                              : base_wide[15:0];
  assign cnt_equal = (qual_cnt_q == base_cnt_q);
  assign qual_done = (qual_cnt_q >= base_cnt_q);

  always_comb begin
    phase_d      = phase_q;
    line_start_d = line_start_q;
    base_cnt_d   = base_cnt_q;
    qual_cnt_d   = qual_cnt_q;
    res_o        = '0;

    if (word_i.op == OP_EOS) begin
      case (phase_q)
        PH_HEADER, PH_SEQ, PH_PLUS: begin
          res_o.valid           = 1'b1;
          res_o.word.kind       = KIND_END;
          res_o.word.status     = ST_TRUNC;
          res_o.word.base_total = base_total;
        end
        PH_QUAL: begin
          res_o.valid           = 1'b1;
          res_o.word.kind       = KIND_END;
          res_o.word.status     = cnt_equal ? ST_OK : ST_MISMATCH;
          res_o.word.base_total = base_total;
        end
        default: ;
      endcase
      // every end-of-stream leaves the parser between records
      phase_d      = PH_AWAIT;
      line_start_d = 1'b1;
      base_cnt_d   = '0;
      qual_cnt_d   = '0;
    end else if (b == CHAR_CR) begin
      // carriage return is invisible
    end else if (b == CHAR_LF) begin
      line_start_d = 1'b1;
      case (phase_q)
        PH_HEADER:  phase_d = PH_SEQ;
        PH_BADSKIP: phase_d = PH_AWAIT;
        PH_SEQ:     ;
        PH_PLUS: begin
          phase_d    = PH_QUAL;
          qual_cnt_d = '0;
        end
        PH_QUAL: begin
          if (qual_done) begin
            res_o.valid           = 1'b1;
            res_o.word.kind       = KIND_END;
            res_o.word.status     = cnt_equal ? ST_OK : ST_MISMATCH;
            res_o.word.base_total = base_total;
            phase_d               = PH_AWAIT;
            base_cnt_d            = '0;
            qual_cnt_d            = '0;
          end
        end
        default: begin
          // empty header line
          res_o.valid       = 1'b1;
          res_o.word.kind   = KIND_END;
          res_o.word.status = ST_BADHDR;
          phase_d           = PH_AWAIT;
          base_cnt_d        = '0;
          qual_cnt_d        = '0;
        end
      endcase
    end else begin
      line_start_d = 1'b0;
      case (phase_q)
        PH_HEADER: begin
          res_o.valid         = 1'b1;
          res_o.word.kind     = KIND_HDR;
          res_o.word.char_out = b;
        end
        PH_BADSKIP, PH_PLUS: ;
        PH_SEQ: begin
          if (line_start_q && (b == CHAR_PLUS)) begin
            phase_d = PH_PLUS;
          end else begin
            base_cnt_d          = base_inc;
            res_o.valid         = 1'b1;
            res_o.word.kind     = KIND_BASE;
            res_o.word.char_out = b;
          end
        end
        PH_QUAL: begin
          qual_cnt_d          = qual_inc;
          res_o.valid         = 1'b1;
          res_o.word.kind     = KIND_QUAL;
          res_o.word.char_out = b;
        end
        default: begin
          res_o.valid = 1'b1;
          base_cnt_d  = '0;
          qual_cnt_d  = '0;
          if (b == CHAR_AT) begin
            phase_d             = PH_HEADER;
            res_o.word.kind     = KIND_HDR;
            res_o.word.char_out = b;
          end else begin
            phase_d           = PH_BADSKIP;
            res_o.word.kind   = KIND_END;
            res_o.word.status = ST_BADHDR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_AWAIT;
      line_start_q <= 1'b1;
      base_cnt_q   <= '0;
      qual_cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      line_start_q <= line_start_d;
      base_cnt_q   <= base_cnt_d;
      qual_cnt_q   <= qual_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (word_i.op == OP_EOS)) |=>
      (phase_q == PH_AWAIT) && (base_cnt_q == '0) && (qual_cnt_q == '0))
    else $error("end of stream did not return to awaiting header");

  a_hdr_lf_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (word_i.op == OP_DATA) && (b == CHAR_LF) && (phase_q == PH_HEADER)) |=>
      (phase_q == PH_SEQ) && line_start_q)
    else $error("header line end did not enter sequence lines");

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.word.kind != KIND_END)) |->
      ((res_o.word.status == ST_OK) && (res_o.word.base_total == 16'd0)))
    else $error("character word carries status fields");
`endif

endmodule

/* rtl/fqp_out_stage.sv */
module fqp_out_stage import fqp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  fqp_res_t res_i,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output fqp_out_t out_word_o,
  output logic     free_o
);

  logic     valid_q, valid_d;
  fqp_out_t word_q;

  // room for a new word when empty or when the held word leaves now
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = res_i.valid;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && res_i.valid) begin
      word_q <= res_i.word;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

/* rtl/fastq_record_parser.sv */
// channel | direction | handshake              | word
// --------+-----------+------------------------+--------------------------------------
// in      | input     | in_valid_i / in_stall_o | fqp_in_t: op, byte_in
// out     | output    | out_valid_o / out_stall_i | fqp_out_t: kind, char_out, status, base_total
//
// one byte or end-of-stream word per cycle while in_stall_o is low; each accepted word
// yields zero or one output word in the next cycle, from the output register
// the parse state update and result select are one level of logic between the
// input handshake and the output register
// reset (rst_ni low, asynchronous) leaves the parser awaiting a record header
// with both counts zero and the output register empty
// in_stall_o rises only while a word sits in the output register and out_stall_i
// holds it; a word that yields no result still waits for that slot
module fastq_record_parser import fqp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fqp_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fqp_out_t out_word_o
);

  logic     accept;
  logic     out_free;
  fqp_res_t res;

  // input stalls only when the output register is full and held
  assign in_stall_o = !out_free;
  assign accept     = in_valid_i && out_free;

  // phase, line start flag and saturating base/quality counters
  fqp_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .word_i  (in_word_i),
    .res_o   (res)
  );

  // result register toward the downstream side
  fqp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .free_o     (out_free)
  );

`ifndef ASSERT_OFF
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.valid) |=> (out_valid_o && (out_word_o == $past(res.word))))
    else $error("result did not reach the output register");
`endif

endmodule
